FILE: hdl/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types, codes and sizes for the randomized set engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int DRAW_BITS      = 16;
    localparam int ACTION_BITS    = 2;
    localparam int STATUS_BITS    = 2;
    localparam int COUNT_OUT_BITS = 7;
    localparam int DEF_CAPACITY   = 64;

    // stream packing
    localparam int IN_DATA_BITS   = 48;  // value, random_draw
    localparam int IN_USER_BITS   = 8;   // action, zero filled
    localparam int OUT_DATA_BITS  = 40;  // picked_value, member_count, zero filled
    localparam int OUT_USER_BITS  = 8;   // ok, status, zero filled

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_PICK   = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE     = 2'd0,
        ST_CONFLICT = 2'd1,  // already present on insert, absent on remove
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_RD_LAST,
        S_MOD,
        S_RD_PICK,
        S_REPLY
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    search_step;
        logic    mod_step;
        logic    rd_last;
        logic    rd_pick;
        logic    finish;
        logic    wr_insert;
        logic    wr_move;
        logic    use_pick;
        logic    ok;
        t_status status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_action action;
        logic    found;
        logic    search_done;
        logic    mod_done;
        logic    empty;
        logic    full;
        logic    out_free;
    } t_stat;

    // pending reply held by the controller
    typedef struct packed {
        logic    ok;
        t_status status;
        logic    wr_insert;
        logic    wr_move;
        logic    use_pick;
    } t_reply;

    function automatic t_reply make_reply(input logic    ok,
                                          input t_status status,
                                          input logic    wr_insert,
                                          input logic    wr_move,
                                          input logic    use_pick);
        t_reply r;
        r.ok        = ok;
        r.status    = status;
        r.wr_insert = wr_insert;
        r.wr_move   = wr_move;
        r.use_pick  = use_pick;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rse_ctrl.sv
// ----------------------------------------------------------------------------
// rse_ctrl
// Request sequencer: dispatch, search, modulo, read and reply steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_fire,
    output logic                o_in_ready,
    input  wire rse_pkg::t_stat i_stat,
    output rse_pkg::t_cmd       o_cmd
);

    rse_pkg::t_state r_state, n_state;
    rse_pkg::t_reply r_reply, n_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rse_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reply <= n_reply;
    end

    always_comb begin
        n_state    = r_state;
        n_reply    = r_reply;
        o_cmd      = '0;
        o_in_ready = (r_state == rse_pkg::S_IDLE);
        case (r_state)
            rse_pkg::S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state    = rse_pkg::S_DISPATCH;
                end
            end
            rse_pkg::S_DISPATCH: begin
                case (i_stat.action)
                    rse_pkg::ACT_INSERT, rse_pkg::ACT_REMOVE: begin
                        n_state = rse_pkg::S_SEARCH;
                    end
                    rse_pkg::ACT_PICK: begin
                        if (i_stat.empty) begin
                            n_reply = rse_pkg::make_reply(1'b0, rse_pkg::ST_EMPTY,
                                                          1'b0, 1'b0, 1'b0);
                            n_state = rse_pkg::S_REPLY;
                        end else begin
                            n_state = rse_pkg::S_MOD;
                        end
                    end
                    default: begin
                        // no-op code
                        n_reply = rse_pkg::make_reply(1'b0, rse_pkg::ST_DONE,
                                                      1'b0, 1'b0, 1'b0);
                        n_state = rse_pkg::S_REPLY;
                    end
                endcase
            end
            rse_pkg::S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_stat.search_done) begin
                    if (i_stat.action == rse_pkg::ACT_INSERT) begin
                        n_state = rse_pkg::S_REPLY;
                        if (i_stat.found) begin
                            n_reply = rse_pkg::make_reply(1'b0, rse_pkg::ST_CONFLICT,
                                                          1'b0, 1'b0, 1'b0);
                        end else if (i_stat.full) begin
                            n_reply = rse_pkg::make_reply(1'b0, rse_pkg::ST_FULL,
                                                          1'b0, 1'b0, 1'b0);
                        end else begin
                            n_reply = rse_pkg::make_reply(1'b1, rse_pkg::ST_DONE,
                                                          1'b1, 1'b0, 1'b0);
                        end
                    end else if (i_stat.found) begin
                        n_state = rse_pkg::S_RD_LAST;
                    end else begin
                        n_reply = rse_pkg::make_reply(1'b0, rse_pkg::ST_CONFLICT,
                                                      1'b0, 1'b0, 1'b0);
                        n_state = rse_pkg::S_REPLY;
                    end
                end
            end
            rse_pkg::S_RD_LAST: begin
                o_cmd.rd_last = 1'b1;
                n_reply = rse_pkg::make_reply(1'b1, rse_pkg::ST_DONE, 1'b0, 1'b1, 1'b0);
                n_state = rse_pkg::S_REPLY;
            end
            rse_pkg::S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_done) begin
                    n_state = rse_pkg::S_RD_PICK;
                end
            end
            rse_pkg::S_RD_PICK: begin
                o_cmd.rd_pick = 1'b1;
                n_reply = rse_pkg::make_reply(1'b1, rse_pkg::ST_DONE, 1'b0, 1'b0, 1'b1);
                n_state = rse_pkg::S_REPLY;
            end
            rse_pkg::S_REPLY: begin
                // store update and result load happen together
                if (i_stat.out_free) begin
                    o_cmd.finish    = 1'b1;
                    o_cmd.ok        = r_reply.ok;
                    o_cmd.status    = r_reply.status;
                    o_cmd.wr_insert = r_reply.wr_insert;
                    o_cmd.wr_move   = r_reply.wr_move;
                    o_cmd.use_pick  = r_reply.use_pick;
                    n_state         = rse_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rse_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/rse_dpath.sv
// ----------------------------------------------------------------------------
// rse_dpath
// Member store, live count, linear search, serial modulo and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_dpath #(
    parameter int CAPACITY = rse_pkg::DEF_CAPACITY
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire rse_pkg::t_cmd                         i_cmd,
    output rse_pkg::t_stat                             o_stat,
    input  wire rse_pkg::t_action                      i_action,
    input  wire logic signed [rse_pkg::VALUE_BITS-1:0] i_value,
    input  wire logic [rse_pkg::DRAW_BITS-1:0]         i_draw,
    input  wire logic                                  i_out_ready,
    output logic                                       o_out_valid,
    output logic                                       o_ok,
    output logic [rse_pkg::STATUS_BITS-1:0]            o_status,
    output logic signed [rse_pkg::VALUE_BITS-1:0]      o_picked_value,
    output logic [rse_pkg::COUNT_OUT_BITS-1:0]         o_member_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int BW = $clog2(rse_pkg::DRAW_BITS + 1);

    logic [rse_pkg::VALUE_BITS-1:0] r_mem [CAPACITY];

    rse_pkg::t_action                 r_action;
    logic [rse_pkg::VALUE_BITS-1:0]   r_value;
    logic [rse_pkg::DRAW_BITS-1:0]    r_div_sh;
    logic [CW-1:0]                    r_rem, n_rem;
    logic [BW-1:0]                    r_bit;
    logic [CW-1:0]                    r_count, n_count;
    logic [CW-1:0]                    r_idx;
    logic                             r_rd_valid;
    logic [AW-1:0]                    r_rd_idx;
    logic [rse_pkg::VALUE_BITS-1:0]   r_rd_data;
    logic                             r_found;
    logic [AW-1:0]                    r_pos;
    logic                             r_out_valid;
    logic                             r_out_ok;
    logic [rse_pkg::STATUS_BITS-1:0]  r_out_status;
    logic [rse_pkg::VALUE_BITS-1:0]   r_out_picked;
    logic [rse_pkg::COUNT_OUT_BITS-1:0] r_out_count;

    logic                           search_issue, hit, mod_done, mod_go;
    logic                           rd_en, wr_en;
    logic [AW-1:0]                  rd_addr, wr_addr, last_idx;
    logic [rse_pkg::VALUE_BITS-1:0] wr_data;
    logic [CW-1:0]                  count_m1;
    logic [CW:0]                    trial;

    assign search_issue = i_cmd.search_step && !r_found && (r_idx < r_count);
    assign hit          = r_rd_valid && (r_rd_data == r_value);
    assign mod_done     = (r_bit == BW'(rse_pkg::DRAW_BITS));
    assign mod_go       = i_cmd.mod_step && !mod_done;
    assign count_m1     = r_count - CW'(1);
    assign last_idx     = count_m1[AW-1:0];

    // restoring step, one draw bit per cycle
    assign trial = {r_rem, r_div_sh[rse_pkg::DRAW_BITS-1]};
    always_comb begin
        if (trial >= {1'b0, r_count}) begin
            n_rem = CW'(trial - {1'b0, r_count});
        end else begin
            n_rem = trial[CW-1:0];
        end
    end

    // single read port
    assign rd_en = search_issue || i_cmd.rd_last || i_cmd.rd_pick;
    always_comb begin
        if (i_cmd.rd_last) begin
            rd_addr = last_idx;
        end else if (i_cmd.rd_pick) begin
            rd_addr = r_rem[AW-1:0];
        end else begin
            rd_addr = r_idx[AW-1:0];
        end
    end

    assign wr_en   = i_cmd.finish && (i_cmd.wr_insert || i_cmd.wr_move);
    assign wr_addr = i_cmd.wr_insert ? r_count[AW-1:0] : r_pos;
    assign wr_data = i_cmd.wr_insert ? r_value : r_rd_data;

    always_comb begin
        n_count = r_count;
        if (i_cmd.finish && i_cmd.wr_insert) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.finish && i_cmd.wr_move) begin
            n_count = count_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_bit       <= '0;
            r_found     <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_rd_valid <= search_issue;
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_bit   <= '0;
                r_found <= 1'b0;
            end else begin
                if (search_issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (hit) begin
                    r_found <= 1'b1;
                end
                if (mod_go) begin
                    r_bit <= r_bit + BW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_value  <= i_value;
            r_div_sh <= i_draw;
            r_rem    <= '0;
        end else if (mod_go) begin
            r_rem    <= n_rem;
            r_div_sh <= {r_div_sh[rse_pkg::DRAW_BITS-2:0], 1'b0};
        end
        if (search_issue) begin
            r_rd_idx <= r_idx[AW-1:0];
        end
        if (hit && !r_found) begin
            r_pos <= r_rd_idx;
        end
        if (i_cmd.finish) begin
            r_out_ok     <= i_cmd.ok;
            r_out_status <= i_cmd.status;
            r_out_picked <= i_cmd.use_pick ? r_rd_data : '0;
            r_out_count  <= rse_pkg::COUNT_OUT_BITS'(n_count);
        end
    end

    always_comb begin
        o_stat.action      = r_action;
        o_stat.found       = r_found;
        o_stat.search_done = r_found || ((r_idx == r_count) && !r_rd_valid);
        o_stat.mod_done    = mod_done;
        o_stat.empty       = (r_count == '0);
        o_stat.full        = (r_count >= CW'(CAPACITY));
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_out_ok;
    assign o_status       = r_out_status;
    assign o_picked_value = r_out_picked;
    assign o_member_count = r_out_count;

endmodule

`default_nettype wire

FILE: hdl/randomized_set_engine.sv
// ----------------------------------------------------------------------------
// randomized_set_engine
// Set of distinct 32-bit values with insert, remove and random pick.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      payload
//  --------  ---  -----------------------------  -------------------------------
//  request   in   s_axis_tvalid / s_axis_tready  tdata: value, random_draw
//                                                tuser: action
//  result    out  m_axis_tvalid / m_axis_tready  tdata: picked_value, member_count
//                                                tuser: ok, status
//
//  One item at a time. Insert and remove run a linear search that reads one
//  store entry per cycle; pick runs the 16-step serial modulo of the draw by
//  the count.
//  A finished result sits in the output register; the next request is taken
//  while it waits, and a full output register only holds the final step.
//  Synchronous active-low reset empties the set; store contents are not cleared.
//
`default_nettype none

module randomized_set_engine #(
    parameter int CAPACITY = rse_pkg::DEF_CAPACITY
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // request
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [rse_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,  // value[31:0], random_draw[47:32]
    input  wire logic [rse_pkg::IN_USER_BITS-1:0]    s_axis_tuser,  // action[1:0], zero fill
    // result
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [rse_pkg::OUT_DATA_BITS-1:0]        m_axis_tdata,  // picked_value[31:0],
                                                                    // member_count[38:32], zero
    output logic [rse_pkg::OUT_USER_BITS-1:0]        m_axis_tuser   // ok[0], status[2:1], zero
);

    rse_pkg::t_cmd  cmd;
    rse_pkg::t_stat stat;

    logic                                in_fire;
    rse_pkg::t_action                    req_action;
    logic signed [rse_pkg::VALUE_BITS-1:0] req_value;
    logic [rse_pkg::DRAW_BITS-1:0]       req_draw;

    logic                                out_ok;
    logic [rse_pkg::STATUS_BITS-1:0]     out_status;
    logic signed [rse_pkg::VALUE_BITS-1:0] out_picked;
    logic [rse_pkg::COUNT_OUT_BITS-1:0]  out_count;

    assign in_fire    = s_axis_tvalid && s_axis_tready;

    // unpack request
    assign req_value  = s_axis_tdata[rse_pkg::VALUE_BITS-1:0];
    assign req_draw   = s_axis_tdata[rse_pkg::VALUE_BITS +: rse_pkg::DRAW_BITS];
    assign req_action = rse_pkg::t_action'(s_axis_tuser[rse_pkg::ACTION_BITS-1:0]);

    rse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rse_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_action       (req_action),
        .i_value        (req_value),
        .i_draw         (req_draw),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_ok           (out_ok),
        .o_status       (out_status),
        .o_picked_value (out_picked),
        .o_member_count (out_count)
    );

    // pack result, zero fill to whole bytes
    assign m_axis_tdata = {
        (rse_pkg::OUT_DATA_BITS - rse_pkg::VALUE_BITS - rse_pkg::COUNT_OUT_BITS)'(0),
        out_count,
        out_picked
    };
    assign m_axis_tuser = {
        (rse_pkg::OUT_USER_BITS - rse_pkg::STATUS_BITS - 1)'(0),
        out_status,
        out_ok
    };

endmodule

`default_nettype wire

FILE: hdl/rse_checker.sv
// ----------------------------------------------------------------------------
// rse_checker
// Port-level checks on the randomized set engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic [rse_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
    input wire logic [rse_pkg::IN_USER_BITS-1:0] s_axis_tuser,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [rse_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    input wire logic [rse_pkg::OUT_USER_BITS-1:0] m_axis_tuser
);

    // one request in flight: no back-to-back accepts
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while previous one still in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed or dropped while stalled");

    // failed requests carry a zero picked value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[31:0] == '0))
        else $error("picked value nonzero without success");

    // success always reports done status
    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[2:1] == rse_pkg::ST_DONE))
        else $error("ok set with failure status");

    // empty report means an empty set
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] == rse_pkg::ST_EMPTY)) |->
            (m_axis_tdata[38:32] == '0))
        else $error("empty status with nonzero member count");

endmodule

bind randomized_set_engine rse_checker u_rse_checker (.*);

`default_nettype wire
